// ===== sv/ced_pkg.sv =====
// Shared types and constants for the curvature extrema detector.
`timescale 1ns / 1ps

package ced_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int THR_W       = 15;
  localparam int POS_W       = 10;
  localparam int CNT_W       = POS_W + 1;
  localparam int MAX_LEN     = 1024;
  localparam int HALF_WINDOW = 3;
  localparam int HIST_DEPTH  = 2 * HALF_WINDOW;
  localparam int THR_RESET   = 819;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = 2;
  localparam int Q_CW        = Q_AW + 1;

  localparam int REG_THRESHOLD = 0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    KIND_MAX  = 2'd0,
    KIND_MIN  = 2'd1,
    KIND_ZERO = 2'd2
  } kind_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    kind_t            kind;
    logic             last;
  } result_t;

  typedef struct packed {
    logic    wr0;
    logic    wr1;
    result_t d0;
    result_t d1;
  } push_t;

endpackage

// ===== sv/ced_queue.sv =====
// Result queue: up to two words pushed and one word popped per cycle.
`timescale 1ns / 1ps

module ced_queue
  import ced_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  push_t         push,
  output logic          room2,
  output logic          out_tvalid,
  input  logic          out_tready,
  output result_t       head
);

  result_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r, wp_nxt;
  logic [Q_AW-1:0]   rp_r, rp_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;
  logic [Q_CW-1:0]   n_wr;
  logic              rd;

  assign rd         = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign head       = mem_r[rp_r];
  assign room2      = (cnt_r <= Q_CW'(Q_DEPTH - 2));
  assign n_wr       = Q_CW'(push.wr0) + Q_CW'(push.wr1);

  always_comb begin
    wp_nxt  = wp_r + n_wr[Q_AW-1:0];
    rp_nxt  = rp_r + Q_AW'(rd);
    cnt_nxt = cnt_r + n_wr - Q_CW'(rd);
  end

  always_ff @(posedge clk) begin
    if (push.wr0) begin
      mem_r[wp_r] <= push.d0;
    end
    if (push.wr1) begin
      mem_r[wp_r + Q_AW'(1)] <= push.d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (Q_CW+1)'(cnt_r) + (Q_CW+1)'(n_wr) <= (Q_CW+1)'(Q_DEPTH))
    else $error("result queue overflow");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.wr1 |-> push.wr0)
    else $error("second push without first");

  a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (rd && cnt_r == Q_CW'(1) && n_wr == '0) |=> (cnt_r == '0))
    else $error("queue count wrong after draining last word");

endmodule

// ===== sv/curvature_extrema_detector.sv =====
// Top level: sample window, extremum and zero-crossing detection, config port.
`timescale 1ns / 1ps

// Takes one curvature sample per clock (Q3.12, signed) with edge_start in
// in_tuser, and reports local maxima, minima and zero crossings by position
// within the edge. An incoming word is registered, then evaluated combinationally
// against a six-sample window and pushed into a four-word result queue;
// a result passes the input stage register and the queue register. One
// sample is accepted per clock while the queue has two free words; a sample
// that gives two results (an extremum three back plus a zero crossing)
// takes two output words, so the output port sets the rate in dense
// stretches. The threshold register sits at byte address 0.
module curvature_extrema_detector
  import ced_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [15:0] sample
  input  logic [15:0] in_tdata,
  // in_tuser: [0] edge_start
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [9:0] position, [15:10] zero
  output logic [15:0] out_tdata,
  // out_tuser: [1:0] kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [THR_W-1:0] thr_r;
  logic             cfg_sel_thr;

  sample_t          stg_sample_r;
  logic             stg_start_r;
  logic             stg_vld_r;

  sample_t          win_r [HIST_DEPTH];
  logic [CNT_W-1:0] pos_r, pos_nxt;

  logic             room2;
  logic             adv;
  logic [CNT_W-1:0] idx;
  logic             active;
  logic             ext_en;
  sample_t          cand;
  logic signed [SAMPLE_W:0] cand_x;
  logic [SAMPLE_W:0] mag;
  logic             big;
  logic             ge_all, le_all;
  logic             is_ext, zc;
  kind_t            ext_kind;
  logic [POS_W-1:0] ext_pos;
  push_t            push;
  result_t          head;

  // configuration
  assign cfg_pready  = 1'b1;
  assign cfg_sel_thr = (cfg_paddr[2] == 1'(REG_THRESHOLD));
  assign cfg_prdata  = cfg_sel_thr ? {{(32-THR_W){1'b0}}, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(THR_RESET);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_thr) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  // input stage
  assign adv       = stg_vld_r && room2;
  assign in_tready = !stg_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_tready) begin
      stg_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_sample_r <= sample_t'(in_tdata);
      stg_start_r  <= in_tuser;
    end
  end

  // detection
  always_comb begin
    idx    = stg_start_r ? '0 : pos_r;
    active = (idx < CNT_W'(MAX_LEN));
    ext_en = active && (idx >= CNT_W'(HIST_DEPTH));
    cand   = win_r[HALF_WINDOW-1];
    cand_x = (SAMPLE_W+1)'(cand);
    mag    = (cand_x < 0) ? (SAMPLE_W+1)'(-cand_x) : (SAMPLE_W+1)'(cand_x);
    big    = (mag > {2'b00, thr_r});

    // max and min both start from zero
    ge_all = (cand >= 0) && (cand >= stg_sample_r);
    le_all = (cand <= 0) && (cand <= stg_sample_r);
    for (int k = 0; k < HIST_DEPTH; k++) begin
      ge_all = ge_all && (cand >= win_r[k]);
      le_all = le_all && (cand <= win_r[k]);
    end

    is_ext   = ext_en && big && (ge_all || le_all);
    ext_kind = ge_all ? KIND_MAX : KIND_MIN;
    ext_pos  = idx[POS_W-1:0] - POS_W'(HALF_WINDOW);

    zc = active && (idx != '0) &&
         (((stg_sample_r > 0) && (win_r[0] < 0)) ||
          ((stg_sample_r < 0) && (win_r[0] > 0)));

    push.wr0 = adv && (is_ext || zc);
    push.wr1 = adv && is_ext && zc;
    if (is_ext) begin
      push.d0 = '{position: ext_pos, kind: ext_kind, last: !zc};
    end else begin
      push.d0 = '{position: idx[POS_W-1:0], kind: KIND_ZERO, last: 1'b1};
    end
    push.d1 = '{position: idx[POS_W-1:0], kind: KIND_ZERO, last: 1'b1};

    pos_nxt = active ? (idx + CNT_W'(1)) : CNT_W'(MAX_LEN);
  end

  // window and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (adv) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_r[0] <= stg_sample_r;
      for (int k = 1; k < HIST_DEPTH; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  ced_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room2      (room2),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = {{(16-POS_W){1'b0}}, head.position};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r && !adv) |=> (stg_vld_r && $stable(stg_sample_r)))
    else $error("input stage lost its word");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("output word changed while stalled");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CNT_W'(MAX_LEN))
    else $error("position counter out of range");

endmodule

// ===== tb/curvature_extrema_detector_tb.sv =====
// Self-checking testbench for curvature_extrema_detector: stream stimulus, predictor, scoreboard.
`timescale 1ns / 1ps

module curvature_extrema_detector_tb;
  import ced_pkg::*;

  class extrema_scoreboard;
    sample_t          window[HIST_DEPTH];
    int               next_pos;
    logic [THR_W-1:0] threshold;
    result_t          expected_q[$];
    int               errors;

    function new();
      foreach (window[k]) window[k] = '0;
      next_pos  = 0;
      threshold = THR_W'(THR_RESET);
      errors    = 0;
    endfunction

    function void set_threshold(logic [THR_W-1:0] value);
      threshold = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_result(int pos, kind_t kind);
      result_t r;
      r.position = POS_W'(pos);
      r.kind     = kind;
      r.last     = 1'b0;
      expected_q = {expected_q, r};
    endfunction

    // Predicts the results caused by one accepted sample word.
    function void note_sample(sample_t cur, logic start);
      int idx, cand, mag, hi, lo, n0;
      n0  = expected_q.size();
      idx = start ? 0 : next_pos;
      if (idx < MAX_LEN) begin
        if (idx >= HIST_DEPTH) begin
          cand = window[HALF_WINDOW-1];
          mag  = (cand < 0) ? -cand : cand;
          hi   = (cur > 0) ? int'(cur) : 0;
          lo   = (cur < 0) ? int'(cur) : 0;
          foreach (window[k]) begin
            if (window[k] > hi) hi = window[k];
            if (window[k] < lo) lo = window[k];
          end
          if (mag > int'(threshold)) begin
            if (cand == hi) add_result(idx - HALF_WINDOW, KIND_MAX);
            else if (cand == lo) add_result(idx - HALF_WINDOW, KIND_MIN);
          end
        end
        if (idx >= 1 && ((cur > 0 && window[0] < 0) || (cur < 0 && window[0] > 0)))
          add_result(idx, KIND_ZERO);
        next_pos = idx + 1;
      end else begin
        next_pos = MAX_LEN;
      end
      for (int k = HIST_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = cur;
      if (expected_q.size() > n0) expected_q[$].last = 1'b1;
    endfunction

    function void check_result(logic [POS_W-1:0] pos, logic [1:0] kind, logic last);
      result_t exp;
      if (expected_q.size() == 0) begin
        if (errors < 50)
          $display("%0t: unexpected word: expected none, actual pos=%0d kind=%0d last=%0b",
                   $realtime, pos, kind, last);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (pos !== exp.position || kind !== exp.kind || last !== exp.last) begin
        if (errors < 50)
          $display({"%0t: mismatch: expected pos=%0d kind=%0d last=%0b, ",
                    "actual pos=%0d kind=%0d last=%0b"},
                   $realtime, exp.position, exp.kind, exp.last, pos, kind, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  extrema_scoreboard sb = new();

  int burst_left = 8;
  int walk_level = 0;
  int stall_mode = 0;
  int stall_left = 0;

  curvature_extrema_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #6 clk = ~clk;

  // Receiver stall pattern: switches at random among four modes.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(30, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (stall_left % 5 != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[POS_W-1:0], out_tuser, out_tlast);
      if (in_tvalid && in_tready)
        sb.note_sample(sample_t'(in_tdata), in_tuser);
    end
  end

  task automatic send_sample(sample_t value, logic start);
    int gap;
    in_tdata  <= value;
    in_tuser  <= start;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 9);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(REG_THRESHOLD * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_threshold(value[THR_W-1:0]);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Mostly a damped random walk, so peaks and sign changes occur; some noise and extremes.
  function automatic sample_t next_sample();
    int pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0: return sample_t'($urandom_range(0, 65535));
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      2: walk_level = int'($urandom_range(0, 65535)) - 32768;
      3: walk_level = 0;
      default: walk_level = walk_level - walk_level / 4 + int'($urandom_range(0, 4000)) - 2000;
    endcase
    if (walk_level > 32767) walk_level = 32767;
    if (walk_level < -32768) walk_level = -32768;
    return sample_t'(walk_level);
  endfunction

  task automatic run_edges(int n_items);
    int count, len;
    count = 0;
    while (count < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 30);
      for (int k = 0; k < len && count < n_items; k++) begin
        send_sample(next_sample(), (k == 0) ? 1'b1 : ($urandom_range(0, 49) == 0));
        count++;
      end
    end
  endtask

  initial begin
    int dir_values[23] = '{10, -10, 20, 1000, 30, -40, 50, 32767, 0, 0, 32767, 100,
                           -32768, -5, -5, -32768, -1, -1, -1, 0, 32767, -1, 5};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First edge without edge_start, ties, max plus crossing, -32768 minimum.
    foreach (dir_values[k])
      send_sample(sample_t'(dir_values[k]), (k == 12 || k == 22));
    drain();

    write_threshold(32'd0);
    run_edges(120);
    drain();

    write_threshold(32'd32767);
    run_edges(80);
    drain();

    write_threshold({17'($urandom), 15'($urandom)});
    run_edges(150);
    drain();

    write_threshold(32'(THR_RESET));
    run_edges(150);
    run_edges(20);
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
